@@ hw/rtl/drt_pkg.sv @@
// Shared types, constants and codes for the dirty rectangle tracker.
// No dependencies; every other file of the tracker except drt_ram uses this package.
`timescale 1ns / 1ps

package drt_pkg;

   // Sizing
   localparam int MAX_ENTRIES = 32;
   localparam int COORD_BITS  = 16;
   localparam int CW          = COORD_BITS;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int ENTRY_W     = 4 * CW;
   localparam int AREA_W      = 2 * CW;
   localparam int QUEUE_DEPTH = 2;

   // Port field widths
   localparam int OP_W     = 2;
   localparam int FIELD_W  = 16;
   localparam int STATUS_W = 3;
   localparam int EIDX_W   = 6;
   localparam int ECNT_W   = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Register reset values
   localparam logic [CW-1:0] SCREEN_W_RESET = CW'(1920);
   localparam logic [CW-1:0] SCREEN_H_RESET = CW'(1080);

   typedef enum logic [0:0] {
      REG_SCREEN_WIDTH  = 1'b0,
      REG_SCREEN_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_DRAIN = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_IGNORED   = 3'd0,
      RS_CONTAINED = 3'd1,
      RS_MERGED    = 3'd2,
      RS_APPENDED  = 3'd3,
      RS_COLLAPSED = 3'd4,
      RS_CLEARED   = 3'd5,
      RS_ENTRY     = 3'd6,
      RS_EMPTY     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      CK_ADD,
      CK_IGNORE,
      CK_CLEAR,
      CK_DRAIN
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_WALK,
      BS_DRAIN,
      BS_EMIT
   } back_state_type;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] w;
      logic [CW-1:0] h;
   } rect_type;

   typedef struct packed {
      cmd_kind_type kind;
      rect_type     rect;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_push_type;

   typedef struct packed {
      logic    empty;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] idx;
      rect_type         rect;
      logic [CNT_W-1:0] count;
      logic             last;
   } rsp_type;

endpackage

@@ hw/rtl/drt_req_if.sv @@
// Request channel of the dirty rectangle tracker: valid/ready plus one command.
// Depends on drt_pkg for field widths.
`timescale 1ns / 1ps

interface drt_req_if;
   logic                          valid;
   logic                          ready;
   logic [drt_pkg::OP_W-1:0]      opcode;
   logic [drt_pkg::FIELD_W-1:0]   rect_left;
   logic [drt_pkg::FIELD_W-1:0]   rect_top;
   logic [drt_pkg::FIELD_W-1:0]   rect_width;
   logic [drt_pkg::FIELD_W-1:0]   rect_height;

   modport source (output valid, opcode, rect_left, rect_top, rect_width, rect_height,
                   input ready);
   modport sink   (input valid, opcode, rect_left, rect_top, rect_width, rect_height,
                   output ready);
endinterface

@@ hw/rtl/drt_rsp_if.sv @@
// Response channel of the dirty rectangle tracker: valid/ready plus one result.
// Depends on drt_pkg for field widths.
`timescale 1ns / 1ps

interface drt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [drt_pkg::STATUS_W-1:0]  status;
   logic [drt_pkg::EIDX_W-1:0]    entry_index;
   logic [drt_pkg::FIELD_W-1:0]   out_left;
   logic [drt_pkg::FIELD_W-1:0]   out_top;
   logic [drt_pkg::FIELD_W-1:0]   out_width;
   logic [drt_pkg::FIELD_W-1:0]   out_height;
   logic [drt_pkg::ECNT_W-1:0]    entry_count;
   logic                          last;

   modport source (output valid, status, entry_index, out_left, out_top, out_width,
                   out_height, entry_count, last, input ready);
   modport sink   (input valid, status, entry_index, out_left, out_top, out_width,
                   out_height, entry_count, last, output ready);
endinterface

@@ hw/rtl/drt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module drt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ hw/rtl/drt_front.sv @@
// Front end: takes request transactions, clips add rectangles to the screen
// and classifies each command for the queue. Depends on drt_pkg, drt_req_if.
`timescale 1ns / 1ps

module drt_front (
   drt_req_if.sink                   req,
   input  logic [drt_pkg::CW-1:0]    screen_w,
   input  logic [drt_pkg::CW-1:0]    screen_h,
   input  logic                      q_full,
   output drt_pkg::q_push_type       q_push
);
   import drt_pkg::*;

   logic [CW-1:0] x;
   logic [CW-1:0] y;
   logic [CW-1:0] w;
   logic [CW-1:0] h;
   logic [CW:0]   right;
   logic [CW:0]   bottom;
   logic          drop;
   rect_type      clipped;

   // Reduce coordinates to the working width
   assign x = req.rect_left[CW-1:0];
   assign y = req.rect_top[CW-1:0];
   assign w = req.rect_width[CW-1:0];
   assign h = req.rect_height[CW-1:0];

   assign right  = {1'b0, x} + {1'b0, w};
   assign bottom = {1'b0, y} + {1'b0, h};
   assign drop   = (w == '0) || (h == '0) || (x >= screen_w) || (y >= screen_h);

   // Clip to the screen
   always_comb begin
      clipped.x = x;
      clipped.y = y;
      clipped.w = (right > {1'b0, screen_w}) ? CW'(screen_w - x) : w;
      clipped.h = (bottom > {1'b0, screen_h}) ? CW'(screen_h - y) : h;
   end

   // Classify
   always_comb begin
      q_push.cmd.rect = clipped;
      unique case (op_type'(req.opcode))
         OP_ADD:   q_push.cmd.kind = drop ? CK_IGNORE : CK_ADD;
         OP_CLEAR: q_push.cmd.kind = CK_CLEAR;
         OP_DRAIN: q_push.cmd.kind = CK_DRAIN;
         OP_RSVD:  q_push.cmd.kind = CK_IGNORE;
      endcase
   end

   assign req.ready   = !q_full;
   assign q_push.push = req.valid && !q_full;
endmodule

@@ hw/rtl/drt_queue.sv @@
// Short command queue between the front end and the list engine.
// Depends on drt_pkg.
`timescale 1ns / 1ps

module drt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  drt_pkg::q_push_type  q_push,
   input  logic                 pop,
   output logic                 full,
   output drt_pkg::q_head_type  head
);
   import drt_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (fill_ff == QC_W'(QUEUE_DEPTH));
   assign head.empty = (fill_ff == '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = q_push.push && !full;
   assign do_pop     = pop && !head.empty;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store commands
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end
endmodule

@@ hw/rtl/drt_back.sv @@
// List engine: holds the rectangle list in RAM, walks it through a compare
// pipeline, appends, collapses, clears and drains. Depends on drt_pkg,
// drt_rsp_if and drt_ram.
`timescale 1ns / 1ps

module drt_back (
   input  logic                     clock,
   input  logic                     reset,
   input  drt_pkg::q_head_type      head,
   output logic                     pop,
   input  logic [drt_pkg::CW-1:0]   screen_w,
   input  logic [drt_pkg::CW-1:0]   screen_h,
   drt_rsp_if.source                rsp
);
   import drt_pkg::*;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   cmd_type          cur_ff, cur_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic             rsp_load;
   logic             slot_free;

   // RAM port
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic                ram_re;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;

   // Compare pipeline
   logic             walk_issue;
   logic             flush;
   logic             s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [IDX_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   rect_type         s2_ent_ff, s3_ent_ff, s4_ent_ff;
   rect_type         s2_box_ff, s3_box_ff, s4_box_ff;
   logic             s2_cont_ff, s3_cont_ff, s4_cont_ff;
   logic             s2_touch_ff, s3_touch_ff, s4_touch_ff;
   logic [AREA_W-1:0] s3_boxa_ff, s3_enta_ff, s3_newa_ff;
   logic [AREA_W-1:0] s4_boxa_ff;
   logic [AREA_W:0]   s4_sum_ff;

   rect_type          ent;
   rect_type          nrect;
   logic [CW:0]       e_right, e_bottom, n_right, n_bottom, b_right, b_bottom;
   logic [CW-1:0]     b_x, b_y;
   rect_type          bbox;
   logic              contain;
   logic              touch;
   logic [AREA_W+1:0] thresh;
   logic              hit;
   logic              pipe_empty;

   drt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_list_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Stage 1: geometry of the entry just read against the new rectangle
   assign ent      = rect_type'(ram_rdata);
   assign nrect    = cur_ff.rect;
   assign e_right  = {1'b0, ent.x} + {1'b0, ent.w};
   assign e_bottom = {1'b0, ent.y} + {1'b0, ent.h};
   assign n_right  = {1'b0, nrect.x} + {1'b0, nrect.w};
   assign n_bottom = {1'b0, nrect.y} + {1'b0, nrect.h};
   assign contain  = (nrect.x >= ent.x) && (nrect.y >= ent.y)
                  && (n_right <= e_right) && (n_bottom <= e_bottom);
   assign touch    = ({1'b0, nrect.x} <= e_right) && (n_right >= {1'b0, ent.x})
                  && ({1'b0, nrect.y} <= e_bottom) && (n_bottom >= {1'b0, ent.y});
   assign b_x      = (nrect.x < ent.x) ? nrect.x : ent.x;
   assign b_y      = (nrect.y < ent.y) ? nrect.y : ent.y;
   assign b_right  = (n_right > e_right) ? n_right : e_right;
   assign b_bottom = (n_bottom > e_bottom) ? n_bottom : e_bottom;

   always_comb begin
      bbox.x = b_x;
      bbox.y = b_y;
      bbox.w = CW'(b_right - {1'b0, b_x});
      bbox.h = CW'(b_bottom - {1'b0, b_y});
   end

   // Decision at the end of the pipeline: floor(3*sum/2) = sum + sum/2
   assign thresh     = (AREA_W+2)'(s4_sum_ff) + (AREA_W+2)'(s4_sum_ff >> 1);
   assign hit        = s4_vld_ff && (s4_cont_ff ||
                       (s4_touch_ff && ((AREA_W+2)'(s4_boxa_ff) < thresh)));
   assign pipe_empty = !s1_vld_ff && !s2_vld_ff && !s3_vld_ff && !s4_vld_ff;
   assign slot_free  = !rsp_vld_ff || rsp.ready;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      cur_in     = cur_ff;
      res_in     = res_ff;
      pop        = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = ENTRY_W'(bbox);
      ram_re     = 1'b0;
      ram_raddr  = IDX_W'(rd_idx_ff);
      walk_issue = 1'b0;
      flush      = 1'b0;
      rsp_load   = 1'b0;
      rsp_in     = res_ff;

      unique case (state_ff)
         BS_IDLE: begin
            if (!head.empty) begin
               pop          = 1'b1;
               cur_in       = head.cmd;
               rd_idx_in    = '0;
               res_in.idx   = '0;
               res_in.rect  = '0;
               res_in.count = count_ff;
               res_in.last  = 1'b1;
               unique case (head.cmd.kind)
                  CK_ADD: begin
                     state_in = BS_WALK;
                  end
                  CK_IGNORE: begin
                     res_in.status = RS_IGNORED;
                     state_in      = BS_EMIT;
                  end
                  CK_CLEAR: begin
                     count_in      = '0;
                     res_in.count  = '0;
                     res_in.status = RS_CLEARED;
                     state_in      = BS_EMIT;
                  end
                  CK_DRAIN: begin
                     if (count_ff == '0) begin
                        res_in.status = RS_EMPTY;
                        state_in      = BS_EMIT;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        state_in  = BS_DRAIN;
                     end
                  end
               endcase
            end
         end

         BS_WALK: begin
            res_in.count = count_ff;
            res_in.last  = 1'b1;
            priority if (hit) begin
               // First containing or mergeable entry ends the walk
               flush      = 1'b1;
               res_in.idx = s4_idx_ff;
               if (s4_cont_ff) begin
                  res_in.status = RS_CONTAINED;
                  res_in.rect   = s4_ent_ff;
               end else begin
                  res_in.status = RS_MERGED;
                  res_in.rect   = s4_box_ff;
                  ram_we        = 1'b1;
                  ram_waddr     = s4_idx_ff;
                  ram_wdata     = ENTRY_W'(s4_box_ff);
               end
               state_in = BS_EMIT;
            end else if ((rd_idx_ff >= count_ff) && pipe_empty) begin
               // Nothing absorbed it: append, or collapse a full list
               ram_we = 1'b1;
               if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                  ram_waddr     = IDX_W'(count_ff);
                  ram_wdata     = ENTRY_W'(cur_ff.rect);
                  res_in.status = RS_APPENDED;
                  res_in.idx    = IDX_W'(count_ff);
                  res_in.rect   = cur_ff.rect;
                  count_in      = count_ff + 1'b1;
                  res_in.count  = count_ff + 1'b1;
               end else begin
                  ram_waddr     = '0;
                  ram_wdata     = ENTRY_W'({CW'(0), CW'(0), screen_w, screen_h});
                  res_in.status = RS_COLLAPSED;
                  res_in.idx    = '0;
                  res_in.rect   = rect_type'({CW'(0), CW'(0), screen_w, screen_h});
                  count_in      = CNT_W'(1);
                  res_in.count  = CNT_W'(1);
               end
               state_in = BS_EMIT;
            end else if (rd_idx_ff < count_ff) begin
               walk_issue = 1'b1;
               ram_re     = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
         end

         BS_DRAIN: begin
            rsp_in.status = RS_ENTRY;
            rsp_in.idx    = IDX_W'(rd_idx_ff);
            rsp_in.rect   = rect_type'(ram_rdata);
            rsp_in.count  = count_ff;
            rsp_in.last   = (rd_idx_ff + 1'b1 == count_ff);
            if (slot_free) begin
               rsp_load = 1'b1;
               if (rsp_in.last) begin
                  state_in = BS_IDLE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = IDX_W'(rd_idx_ff + 1'b1);
                  rd_idx_in = rd_idx_ff + 1'b1;
               end
            end
         end

         BS_EMIT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = BS_IDLE;
            end
         end
      endcase
   end

   // Hold output until taken
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BS_IDLE;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         rsp_vld_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         rsp_vld_ff <= rsp_vld_in;
         s1_vld_ff  <= walk_issue;
         s2_vld_ff  <= s1_vld_ff && !flush;
         s3_vld_ff  <= s2_vld_ff && !flush;
         s4_vld_ff  <= s3_vld_ff && !flush;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
      // stage 1
      s1_idx_ff   <= IDX_W'(rd_idx_ff);
      // stage 2: geometry
      s2_idx_ff   <= s1_idx_ff;
      s2_ent_ff   <= ent;
      s2_box_ff   <= bbox;
      s2_cont_ff  <= contain;
      s2_touch_ff <= touch;
      // stage 3: areas
      s3_idx_ff   <= s2_idx_ff;
      s3_ent_ff   <= s2_ent_ff;
      s3_box_ff   <= s2_box_ff;
      s3_cont_ff  <= s2_cont_ff;
      s3_touch_ff <= s2_touch_ff;
      s3_boxa_ff  <= s2_box_ff.w * s2_box_ff.h;
      s3_enta_ff  <= s2_ent_ff.w * s2_ent_ff.h;
      s3_newa_ff  <= cur_ff.rect.w * cur_ff.rect.h;
      // stage 4: area sum
      s4_idx_ff   <= s3_idx_ff;
      s4_ent_ff   <= s3_ent_ff;
      s4_box_ff   <= s3_box_ff;
      s4_cont_ff  <= s3_cont_ff;
      s4_touch_ff <= s3_touch_ff;
      s4_boxa_ff  <= s3_boxa_ff;
      s4_sum_ff   <= (AREA_W+1)'(s3_enta_ff) + (AREA_W+1)'(s3_newa_ff);
   end

   // Drive the response channel
   assign rsp.valid       = rsp_vld_ff;
   assign rsp.status      = rsp_ff.status;
   assign rsp.entry_index = EIDX_W'(rsp_ff.idx);
   assign rsp.out_left    = FIELD_W'(rsp_ff.rect.x);
   assign rsp.out_top     = FIELD_W'(rsp_ff.rect.y);
   assign rsp.out_width   = FIELD_W'(rsp_ff.rect.w);
   assign rsp.out_height  = FIELD_W'(rsp_ff.rect.h);
   assign rsp.entry_count = ECNT_W'(rsp_ff.count);
   assign rsp.last        = rsp_ff.last;

   // List RAM is only written when a walk ends
   a_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == BS_WALK))
      else $error("list write outside a walk");

   // Pipeline valid only advances from the stage before it
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff |-> $past(s3_vld_ff))
      else $error("compare pipeline skipped a stage");

   // Walk reads stay inside the stored entries
   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      (ram_re && (state_ff == BS_WALK)) |-> (rd_idx_ff < count_ff))
      else $error("walk read beyond list");

   // Drain only runs on a non-empty list
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_DRAIN) |-> (count_ff != '0))
      else $error("drain of an empty list");
endmodule

@@ hw/rtl/dirty_rect_tracker_top.sv @@
// Dirty rectangle tracker: top level with the APB-style register port.
// Depends on drt_pkg, drt_req_if, drt_rsp_if, drt_front, drt_queue, drt_back.
`timescale 1ns / 1ps

// For an add command the list RAM is read one entry per cycle into a
// four-stage compare pipeline, and the walk stops as soon as the first
// containing or mergeable entry reaches the end of it. A drain returns the
// stored entries, one result per cycle while the output is taken. A two-entry
// command queue lets new requests enter while the engine works. The list needs
// no clearing after reset; only entries below the count are ever read.
module dirty_rect_tracker_top (
   input  logic                           clock,
   input  logic                           reset,
   drt_req_if.sink                        req_chan,
   drt_rsp_if.source                      rsp_chan,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [drt_pkg::CSR_AW-1:0]     paddr,
   input  logic [drt_pkg::CSR_DW-1:0]     pwdata,
   output logic [drt_pkg::CSR_DW-1:0]     prdata,
   output logic                           pready
);
   import drt_pkg::*;

   logic [CW-1:0] screen_w_ff;
   logic [CW-1:0] screen_h_ff;
   logic          csr_wr;
   reg_index_type csr_sel;
   q_push_type    q_push;
   q_head_type    q_head;
   logic          q_full;
   logic          q_pop;

   // Register port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= SCREEN_W_RESET;
         screen_h_ff <= SCREEN_H_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_SCREEN_WIDTH:  screen_w_ff <= pwdata[CW-1:0];
            REG_SCREEN_HEIGHT: screen_h_ff <= pwdata[CW-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_SCREEN_WIDTH:  prdata = CSR_DW'(screen_w_ff);
         REG_SCREEN_HEIGHT: prdata = CSR_DW'(screen_h_ff);
      endcase
   end

   drt_front u_front (
      .req      (req_chan),
      .screen_w (screen_w_ff),
      .screen_h (screen_h_ff),
      .q_full   (q_full),
      .q_push   (q_push)
   );

   drt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (q_pop),
      .full   (q_full),
      .head   (q_head)
   );

   drt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .screen_w (screen_w_ff),
      .screen_h (screen_h_ff),
      .rsp      (rsp_chan)
   );
endmodule

@@ verif/drt_checker.sv @@
// Checker for the dirty rectangle tracker: watches both channels, predicts
// the list behavior and compares results. Depends on drt_pkg and the channel interfaces.
`timescale 1ns / 1ps

module drt_checker (
   input  logic        clock,
   input  logic        reset,
   drt_req_if          req,
   drt_rsp_if          rsp,
   input  logic [15:0] screen_w,
   input  logic [15:0] screen_h,
   output int          fail_count,
   output int          pending
);
   import drt_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  idx;
      logic [15:0] x, y, w, h;
      logic [6:0]  count;
      logic        last;
   } result_type;

   typedef struct {
      logic [16:0] x, y, w, h;
   } box_type;

   box_type     shadow_list[MAX_ENTRIES];
   int          shadow_count;
   result_type  expected_q[$];

   assign pending = expected_q.size();

   // Queue one result for the current list
   function automatic void push_result(logic [2:0] st, int idx, box_type b, logic lst);
      result_type r;
      r.status = st;
      r.idx    = idx[5:0];
      r.x      = b.x[15:0];
      r.y      = b.y[15:0];
      r.w      = b.w[15:0];
      r.h      = b.h[15:0];
      r.count  = shadow_count[6:0];
      r.last   = lst;
      expected_q.push_back(r);
   endfunction

   // Apply one add transaction to the shadow list
   function automatic void predict_add(logic [15:0] l, logic [15:0] t, logic [15:0] wd,
                                       logic [15:0] ht);
      box_type     zero_box, n, d;
      logic [16:0] sw, sh, dr, db, nx, ny, nr, nb;
      logic [63:0] area_box, area_sum;
      zero_box = '{0, 0, 0, 0};
      sw = screen_w;
      sh = screen_h;
      n = '{l, t, wd, ht};
      if (wd == 0 || ht == 0 || n.x >= sw || n.y >= sh) begin
         push_result(RS_IGNORED, 0, zero_box, 1'b1);
         return;
      end
      if (n.x + n.w > sw) n.w = sw - n.x;
      if (n.y + n.h > sh) n.h = sh - n.y;
      for (int i = 0; i < shadow_count; i++) begin
         d  = shadow_list[i];
         dr = d.x + d.w;
         db = d.y + d.h;
         if (n.x >= d.x && n.y >= d.y && n.x + n.w <= dr && n.y + n.h <= db) begin
            push_result(RS_CONTAINED, i, d, 1'b1);
            return;
         end
         if (n.x <= dr && n.x + n.w >= d.x && n.y <= db && n.y + n.h >= d.y) begin
            nx = (n.x < d.x) ? n.x : d.x;
            ny = (n.y < d.y) ? n.y : d.y;
            nr = (n.x + n.w > dr) ? n.x + n.w : dr;
            nb = (n.y + n.h > db) ? n.y + n.h : db;
            area_box = 64'(nr - nx) * 64'(nb - ny);
            area_sum = 64'(d.w) * 64'(d.h) + 64'(n.w) * 64'(n.h);
            if (area_box < area_sum * 3 / 2) begin
               shadow_list[i] = '{nx, ny, nr - nx, nb - ny};
               push_result(RS_MERGED, i, shadow_list[i], 1'b1);
               return;
            end
         end
      end
      if (shadow_count < MAX_ENTRIES) begin
         shadow_list[shadow_count] = n;
         shadow_count++;
         push_result(RS_APPENDED, shadow_count - 1, n, 1'b1);
      end else begin
         shadow_list[0] = '{0, 0, sw, sh};
         shadow_count = 1;
         push_result(RS_COLLAPSED, 0, shadow_list[0], 1'b1);
      end
   endfunction

   // Predict on each accepted request, compare each accepted result
   always @(posedge clock) begin
      box_type    zero_box;
      result_type got, exp_r;
      zero_box = '{0, 0, 0, 0};
      if (reset) begin
         shadow_count <= 0;
         fail_count   <= 0;
         expected_q.delete();
      end else begin
         if (req.valid && req.ready) begin
            case (op_type'(req.opcode))
               OP_ADD: predict_add(req.rect_left, req.rect_top, req.rect_width,
                                   req.rect_height);
               OP_CLEAR: begin
                  shadow_count = 0;
                  push_result(RS_CLEARED, 0, zero_box, 1'b1);
               end
               OP_DRAIN: begin
                  if (shadow_count == 0) push_result(RS_EMPTY, 0, zero_box, 1'b1);
                  else
                     for (int i = 0; i < shadow_count; i++)
                        push_result(RS_ENTRY, i, shadow_list[i], i == shadow_count - 1);
               end
               default: push_result(RS_IGNORED, 0, zero_box, 1'b1);
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.status, rsp.entry_index, rsp.out_left, rsp.out_top,
                    rsp.out_width, rsp.out_height, rsp.entry_count, rsp.last};
            if (expected_q.size() == 0) begin
               $error("unexpected result transaction status=%0d", got.status);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got != exp_r) begin
                  fail_count <= fail_count + 1;
                  if (got.status != exp_r.status)
                     $error("status exp %0d got %0d", exp_r.status, got.status);
                  if (got.idx != exp_r.idx)
                     $error("entry_index exp %0d got %0d", exp_r.idx, got.idx);
                  if (got.x != exp_r.x) $error("out_left exp %0d got %0d", exp_r.x, got.x);
                  if (got.y != exp_r.y) $error("out_top exp %0d got %0d", exp_r.y, got.y);
                  if (got.w != exp_r.w) $error("out_width exp %0d got %0d", exp_r.w, got.w);
                  if (got.h != exp_r.h) $error("out_height exp %0d got %0d", exp_r.h, got.h);
                  if (got.count != exp_r.count)
                     $error("entry_count exp %0d got %0d", exp_r.count, got.count);
                  if (got.last != exp_r.last)
                     $error("last exp %0d got %0d", exp_r.last, got.last);
               end
            end
         end
      end
   end
endmodule

@@ verif/dirty_rect_tracker_top_tb.sv @@
// Testbench top for the dirty rectangle tracker: clock, reset, register
// writes, request stimulus and verdict. Depends on drt_pkg, the interfaces and drt_checker.
`timescale 1ns / 1ps

module dirty_rect_tracker_top_tb;
   import drt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic        pready;
   logic [15:0] screen_w = 16'd1920, screen_h = 16'd1080;
   int          fail_count, pending;
   bit          calm_stretch = 1'b0;

   drt_req_if req_chan ();
   drt_rsp_if rsp_chan ();

   dirty_rect_tracker_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   drt_checker checker_i (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .screen_w(screen_w), .screen_h(screen_h),
      .fail_count(fail_count), .pending(pending)
   );

   always #2 clock = ~clock;

   // Stall the result side at random
   initial rsp_chan.ready = 1'b0;
   always @(posedge clock) begin
      rsp_chan.ready <= calm_stretch || ($urandom_range(99) >= 7);
   end

   // Write one register through setup and access cycles
   task automatic write_screen(reg_index_type reg_id, logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= CSR_AW'(4 * int'(reg_id)); pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (reg_id == REG_SCREEN_WIDTH) screen_w <= value;
      else screen_h <= value;
   endtask

   // Drain all expectations, then let the engine settle
   task automatic settle();
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Send one request transaction, with random idle cycles before it
   task automatic send_request(op_type op, logic [15:0] l, logic [15:0] t,
                               logic [15:0] wd, logic [15:0] ht);
      while (!calm_stretch && $urandom_range(99) < 7) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.rect_left <= l; req_chan.rect_top <= t;
      req_chan.rect_width <= wd; req_chan.rect_height <= ht;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic go_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random add, mostly near the screen, with clustered sizes
   task automatic random_add();
      logic [15:0] l, t, wd, ht;
      case ($urandom_range(9))
         0: begin
            l = 16'($urandom); t = 16'($urandom); wd = 16'($urandom); ht = 16'($urandom);
         end
         1: begin
            l = 16'($urandom_range(screen_w + 20)); t = 16'($urandom_range(screen_h + 20));
            wd = 16'($urandom_range(2)); ht = 16'($urandom_range(2));
         end
         default: begin
            l = 16'($urandom_range(screen_w)); t = 16'($urandom_range(screen_h));
            wd = 16'($urandom_range(1, screen_w / 3 + 1));
            ht = 16'($urandom_range(1, screen_h / 3 + 1));
         end
      endcase
      send_request(OP_ADD, l, t, wd, ht);
   endtask

   task automatic random_phase(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) random_add();
         else if (pick < 86)
            send_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
         else if (pick < 97)
            send_request(OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
         else
            send_request(OP_RSVD, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
      end
   endtask

   initial begin
      req_chan.valid = 1'b0; req_chan.opcode = OP_ADD;
      req_chan.rect_left = '0; req_chan.rect_top = '0;
      req_chan.rect_width = '0; req_chan.rect_height = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset screen size, edge cases of every operation
      send_request(OP_DRAIN, 0, 0, 0, 0);
      send_request(OP_ADD, 0, 0, 0, 5);
      send_request(OP_ADD, 0, 0, 5, 0);
      send_request(OP_ADD, 1920, 0, 5, 5);
      send_request(OP_ADD, 0, 1080, 5, 5);
      send_request(OP_ADD, 100, 100, 100, 100);
      send_request(OP_ADD, 120, 120, 20, 20);
      send_request(OP_ADD, 200, 100, 50, 100);
      send_request(OP_ADD, 1000, 1000, 16'hFFFF, 16'hFFFF);
      send_request(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_RSVD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(OP_DRAIN, 0, 0, 0, 0);
      // Fill past capacity to force a collapse
      for (int i = 0; i < 33; i++) send_request(OP_ADD, 16'(50 * i), 16'(3 * i), 10, 1);
      send_request(OP_DRAIN, 0, 0, 0, 0);
      send_request(OP_CLEAR, 0, 0, 0, 0);
      go_idle();
      settle();

      // Random part over several screen sizes, extremes among them
      random_phase(50);
      go_idle(); settle();
      write_screen(REG_SCREEN_WIDTH, 16'hFFFF);
      write_screen(REG_SCREEN_HEIGHT, 16'hFFFF);
      random_phase(30);
      go_idle(); settle();
      write_screen(REG_SCREEN_WIDTH, 16'd1);
      write_screen(REG_SCREEN_HEIGHT, 16'd1);
      random_phase(15);
      go_idle(); settle();
      write_screen(REG_SCREEN_WIDTH, 16'd0);
      random_phase(8);
      go_idle(); settle();
      write_screen(REG_SCREEN_WIDTH, 16'd64);
      write_screen(REG_SCREEN_HEIGHT, 16'd48);
      calm_stretch = 1'b1;
      random_phase(40);
      calm_stretch = 1'b0;
      random_phase(20);
      go_idle();

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/drt_pkg.sv
hw/rtl/drt_req_if.sv
hw/rtl/drt_rsp_if.sv
hw/rtl/drt_ram.sv
hw/rtl/drt_front.sv
hw/rtl/drt_queue.sv
hw/rtl/drt_back.sv
hw/rtl/dirty_rect_tracker_top.sv
verif/drt_checker.sv
verif/dirty_rect_tracker_top_tb.sv
